### hw/rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Implication checked on every clock edge, reset included.
`define CHK_ALWAYS(label, clk, cond, msg) \
   label: assert property (@(posedge clk) (cond)) else $error(msg);
`endif

### hw/rtl/sbq_pkg.sv
// Package with the shared types, constants and helpers of the biquad equaliser.
package sbq_pkg;
   localparam int STAGES      = 4;
   localparam int SAMPLE_BITS = 24;
   localparam int COEF_BITS   = 32;
   localparam int COEF_FRAC   = COEF_BITS - 5;
   localparam int DELAY_BITS  = SAMPLE_BITS + 8;
   localparam int NCOEF       = STAGES * 5;
   localparam int NDELAY      = STAGES * 2 * 2;
   localparam int CIDX_BITS   = 5;
   localparam int DIDX_BITS   = $clog2(NDELAY);
   localparam int ACC_BITS    = COEF_BITS + DELAY_BITS + 4;
   localparam int PROD_BITS   = COEF_BITS + DELAY_BITS;

   localparam logic [1:0] FUNC_SAMPLE = 2'd0;
   localparam logic [1:0] FUNC_COEF   = 2'd1;
   localparam logic [1:0] FUNC_CLEAR  = 2'd2;

   localparam logic [15:0] MIX_ONE = 16'd32768;

   // One classified request as it travels through the queue.
   typedef struct packed {
      logic [1:0]                   func;
      logic signed [SAMPLE_BITS-1:0] left;
      logic signed [SAMPLE_BITS-1:0] right;
      logic                          eob;
      logic [CIDX_BITS-1:0]          cidx;
      logic signed [COEF_BITS-1:0]   cval;
   } cmd_type;

   // Identity coefficient for a table slot.
   function automatic logic signed [COEF_BITS-1:0] coef_reset(input logic [CIDX_BITS-1:0] idx);
      logic signed [COEF_BITS-1:0] one;
      one = '0;
      one[COEF_FRAC] = 1'b1;
      return (idx == 5'd0 || idx == 5'd5 || idx == 5'd10 || idx == 5'd15) ? one : '0;
   endfunction
endpackage

### hw/rtl/sbq_front.sv
// Front end: accepts requests, drops unused codes and queues the rest.
module sbq_front import sbq_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_func,
   input  logic signed [SAMPLE_BITS-1:0] req_left_sample,
   input  logic signed [SAMPLE_BITS-1:0] req_right_sample,
   input  logic                          req_end_of_block,
   input  logic [CIDX_BITS-1:0]          req_coef_index,
   input  logic signed [COEF_BITS-1:0]   req_coef_value,
   output logic                          q_valid,
   input  logic                          q_ready,
   output cmd_type                       q_cmd
);
   // Two-entry queue.
   cmd_type     mem_ff [2];
   cmd_type     mem_in;
   logic        wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push, pop, keep;

   assign req_ready = (cnt_ff != 2'd2);
   assign keep      = (req_func == FUNC_SAMPLE) || (req_func == FUNC_COEF) ||
                      (req_func == FUNC_CLEAR);
   assign push      = req_valid && req_ready && keep;
   assign q_valid   = (cnt_ff != 2'd0);
   assign pop       = q_valid && q_ready;
   assign q_cmd     = mem_ff[rp_ff];

   always_comb begin
      mem_in = '{func: req_func, left: req_left_sample, right: req_right_sample,
                 eob: req_end_of_block, cidx: req_coef_index, cval: req_coef_value};
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= mem_in;
      end
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

### hw/rtl/sbq_back.sv
// Back end: sequencer with one shared multiply-accumulate unit.
module sbq_back import sbq_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   output logic                          q_ready,
   input  cmd_type                       q_cmd,
   input  logic [15:0]                   wet_mix,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0] rsp_right_out,
   output logic                          rsp_end_of_block_out,
   output logic                          rsp_saturated
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MAC  = 3'd1;
   localparam logic [2:0] ST_RND  = 3'd2;
   localparam logic [2:0] ST_MIXM = 3'd3;
   localparam logic [2:0] ST_MIXA = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   localparam logic signed [DELAY_BITS-1:0] DMAX = {1'b0, {(DELAY_BITS-1){1'b1}}};
   localparam logic signed [DELAY_BITS-1:0] DMIN = {1'b1, {(DELAY_BITS-1){1'b0}}};
   localparam logic signed [DELAY_BITS+2:0] OMAX = (1 <<< (SAMPLE_BITS-1)) - 1;
   localparam logic signed [DELAY_BITS+2:0] OMIN = -(1 <<< (SAMPLE_BITS-1));

   // Coefficients and delays live in flip-flops with per-entry reset.
   logic signed [COEF_BITS-1:0]  coef_ff  [NCOEF];
   logic signed [DELAY_BITS-1:0] delay_ff [NDELAY];

   logic [2:0]  st_ff;
   logic [1:0]  term_ff;     // term within the half-step
   logic        half_ff;     // 0: feedback, 1: feed-forward
   logic [$clog2(STAGES)-1:0] stg_ff;
   logic        ch_ff;
   logic signed [ACC_BITS-1:0]   acc_ff;
   logic signed [PROD_BITS-1:0]  prod_ff;
   logic        pvalid_ff;
   logic signed [DELAY_BITS-1:0] x_ff, w_ff;
   logic signed [DELAY_BITS-1:0] eq_ff [2];
   logic        clip_ff;
   cmd_type     cmd_ff;
   logic [15:0] mix_ff;
   logic        mixch_ff;
   logic signed [DELAY_BITS+17:0] mprod_ff;

   logic signed [SAMPLE_BITS-1:0] lout_ff, rout_ff;
   logic        ovalid_ff, oeob_ff, osat_ff;

   // Operand selection for the multiply.
   logic [CIDX_BITS-1:0]          cb;
   logic [DIDX_BITS-1:0]          zb;
   logic signed [COEF_BITS-1:0]   ma;
   logic signed [DELAY_BITS-1:0]  mb;
   logic signed [ACC_BITS-1:0]    rsum;
   logic signed [ACC_BITS-COEF_FRAC-1:0] rsh;
   logic signed [DELAY_BITS-1:0]  rsat;
   logic        rclip;
   logic signed [DELAY_BITS:0]    diff;
   logic signed [DELAY_BITS+2:0]  osum;
   logic signed [SAMPLE_BITS-1:0] osat;
   logic        oclip;

   assign cb = {1'b0, stg_ff, 2'b00} + {3'b000, stg_ff};
   assign zb = {stg_ff, ch_ff, 1'b0};

   // Feedback terms use the plain coefficient; the accumulator subtracts them.
   always_comb begin
      ma = '0;
      mb = '0;
      case ({half_ff, term_ff})
         3'b000: begin ma = '0; ma[COEF_FRAC] = 1'b1; mb = x_ff; end
         3'b001: begin ma = coef_ff[cb + 5'd3]; mb = delay_ff[zb]; end
         3'b010: begin ma = coef_ff[cb + 5'd4]; mb = delay_ff[zb+1'b1]; end
         3'b100: begin ma = coef_ff[cb];        mb = w_ff; end
         3'b101: begin ma = coef_ff[cb + 5'd1]; mb = delay_ff[zb]; end
         3'b110: begin ma = coef_ff[cb + 5'd2]; mb = delay_ff[zb+1'b1]; end
         default: begin ma = '0; mb = '0; end
      endcase
   end

   // Rounding and saturation of the finished sum.
   always_comb begin
      rsum  = acc_ff + (ACC_BITS'(1) <<< (COEF_FRAC-1));
      rsh   = rsum[ACC_BITS-1:COEF_FRAC];
      rclip = 1'b0;
      rsat  = rsh[DELAY_BITS-1:0];
      if (rsh > $signed((ACC_BITS-COEF_FRAC)'(DMAX))) begin
         rsat = DMAX; rclip = 1'b1;
      end else if (rsh < $signed((ACC_BITS-COEF_FRAC)'(DMIN))) begin
         rsat = DMIN; rclip = 1'b1;
      end
   end

   // Mix output: in plus rounded blend term, saturated.
   always_comb begin
      logic signed [SAMPLE_BITS-1:0] xin;
      xin  = mixch_ff ? cmd_ff.right : cmd_ff.left;
      diff = {eq_ff[mixch_ff][DELAY_BITS-1], eq_ff[mixch_ff]}
             - (DELAY_BITS+1)'(xin);
      osum = (DELAY_BITS+3)'(xin) + (DELAY_BITS+3)'((mprod_ff + 16384) >>> 15);
      oclip = 1'b0;
      osat  = osum[SAMPLE_BITS-1:0];
      if (osum > OMAX) begin
         osat = OMAX[SAMPLE_BITS-1:0]; oclip = 1'b1;
      end else if (osum < OMIN) begin
         osat = OMIN[SAMPLE_BITS-1:0]; oclip = 1'b1;
      end
   end

   assign q_ready = (st_ff == ST_IDLE) && !(ovalid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= ST_IDLE;
         ovalid_ff <= 1'b0;
         pvalid_ff <= 1'b0;
         for (int i = 0; i < NCOEF; i++) coef_ff[i] <= coef_reset(CIDX_BITS'(i));
         for (int i = 0; i < NDELAY; i++) delay_ff[i] <= '0;
      end else begin
         if (rsp_valid && rsp_ready && st_ff != ST_OUT) ovalid_ff <= 1'b0;
         case (st_ff)
            ST_IDLE: begin
               if (q_valid && q_ready) begin
                  cmd_ff  <= q_cmd;
                  mix_ff  <= (wet_mix > MIX_ONE) ? MIX_ONE : wet_mix;
                  if (q_cmd.func == FUNC_COEF && q_cmd.cidx < NCOEF)
                     coef_ff[q_cmd.cidx] <= q_cmd.cval;
                  if (q_cmd.func == FUNC_CLEAR)
                     for (int i = 0; i < NDELAY; i++) delay_ff[i] <= '0;
                  stg_ff    <= '0;
                  ch_ff     <= 1'b0;
                  half_ff   <= 1'b0;
                  term_ff   <= 2'd0;
                  acc_ff    <= '0;
                  pvalid_ff <= 1'b0;
                  clip_ff   <= 1'b0;
                  x_ff      <= DELAY_BITS'(q_cmd.left);
                  st_ff     <= (q_cmd.func == FUNC_SAMPLE) ? ST_MAC : ST_IDLE;
               end
            end
            ST_MAC: begin
               // Multiply into the product register, then add or subtract the product into the accumulator.
               if (!pvalid_ff) begin
                  prod_ff   <= ma * mb;
                  pvalid_ff <= 1'b1;
               end else begin
                  acc_ff    <= (!half_ff && term_ff != 2'd0) ?
                               acc_ff - ACC_BITS'(prod_ff) : acc_ff + ACC_BITS'(prod_ff);
                  pvalid_ff <= 1'b0;
                  if (term_ff == 2'd2) st_ff <= ST_RND;
                  else term_ff <= term_ff + 2'd1;
               end
            end
            ST_RND: begin
               clip_ff <= clip_ff | rclip;
               acc_ff  <= '0;
               term_ff <= 2'd0;
               if (!half_ff) begin
                  w_ff    <= rsat;
                  half_ff <= 1'b1;
                  st_ff   <= ST_MAC;
               end else begin
                  delay_ff[zb+1'b1] <= delay_ff[zb];
                  delay_ff[zb]      <= w_ff;
                  half_ff <= 1'b0;
                  if (stg_ff == STAGES-1) begin
                     eq_ff[ch_ff] <= rsat;
                     if (ch_ff) begin
                        mixch_ff <= 1'b0;
                        st_ff    <= ST_MIXM;
                     end else begin
                        ch_ff  <= 1'b1;
                        stg_ff <= '0;
                        x_ff   <= DELAY_BITS'(cmd_ff.right);
                        st_ff  <= ST_MAC;
                     end
                  end else begin
                     stg_ff <= stg_ff + 1'b1;
                     x_ff   <= rsat;
                     st_ff  <= ST_MAC;
                  end
               end
            end
            ST_MIXM: begin
               mprod_ff <= (DELAY_BITS+18)'(diff) * $signed({1'b0, mix_ff});
               st_ff    <= ST_MIXA;
            end
            ST_MIXA: begin
               clip_ff <= clip_ff | oclip;
               if (mixch_ff) begin
                  rout_ff <= osat;
                  st_ff   <= ST_OUT;
               end else begin
                  lout_ff  <= osat;
                  mixch_ff <= 1'b1;
                  st_ff    <= ST_MIXM;
               end
            end
            ST_OUT: begin
               if (!ovalid_ff || rsp_ready) begin
                  ovalid_ff <= 1'b1;
                  oeob_ff   <= cmd_ff.eob;
                  osat_ff   <= clip_ff;
                  st_ff     <= ST_IDLE;
               end
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid            = ovalid_ff;
   assign rsp_left_out         = lout_ff;
   assign rsp_right_out        = rout_ff;
   assign rsp_end_of_block_out = oeob_ff;
   assign rsp_saturated        = osat_ff;
endmodule

### hw/rtl/sbq_csr.sv
// Configuration register file holding the blend weight.
module sbq_csr import sbq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic [15:0] wet_mix
);
   logic [15:0] mix_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 2'd0) ? {16'd0, mix_ff} : 32'd0;
   assign wet_mix    = mix_ff;

   // Register write at the access phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         mix_ff <= MIX_ONE;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 2'd0) begin
         mix_ff <= csr_pwdata[15:0];
      end
   end
endmodule

### hw/rtl/stereo_biquad_cascade_mix_core.sv
// The back end takes a new sample pair only once the last one is done: its shared
// multiplier forms 48 products and the rounder takes 16 rounding steps per pair, then
// the mixer blends both channels and the result is registered; a stalled result holds
// the next pair back.
// Coefficient writes and clears are applied as the back end accepts them.
// Synchronous reset restores identity coefficients, zero delays and full wet mix.
module stereo_biquad_cascade_mix_core import sbq_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_func,
   input  logic signed [SAMPLE_BITS-1:0] req_left_sample,
   input  logic signed [SAMPLE_BITS-1:0] req_right_sample,
   input  logic                          req_end_of_block,
   input  logic [CIDX_BITS-1:0]          req_coef_index,
   input  logic signed [COEF_BITS-1:0]   req_coef_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0] rsp_right_out,
   output logic                          rsp_end_of_block_out,
   output logic                          rsp_saturated,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [1:0]                    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   logic        q_valid, q_ready;
   cmd_type     q_cmd;
   logic [15:0] wet_mix;

   sbq_csr u_csr (.*);

   sbq_front u_front (.*);

   sbq_back u_back (.*);
endmodule

### hw/rtl/sbq_checker.sv
// Port-level checker for the equaliser core and its bind.
`include "assert_macros.svh"
module sbq_checker import sbq_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_end_of_block_out,
   input logic csr_pready
);
   `CHK_ALWAYS(a_pready, clock, csr_pready, "pready low")
   `CHK_IMPLY(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> rsp_valid, "result dropped")
   `CHK_IMPLY(a_eob_hold, clock, reset, (rsp_valid && !rsp_ready) |=> $stable(rsp_end_of_block_out), "result changed")
   `CHK_IMPLY(a_rst_out, clock, reset, $past(reset) |-> !rsp_valid, "result after reset")
endmodule

bind stereo_biquad_cascade_mix_core sbq_checker u_chk (.*);

### tb/stereo_biquad_cascade_mix_core_checker.sv
// Checker for the stereo biquad equaliser: predicts each result and compares it.
module stereo_biquad_cascade_mix_core_checker import sbq_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [1:0]                    req_func,
   input  logic signed [SAMPLE_BITS-1:0] req_left_sample,
   input  logic signed [SAMPLE_BITS-1:0] req_right_sample,
   input  logic                          req_end_of_block,
   input  logic [CIDX_BITS-1:0]          req_coef_index,
   input  logic signed [COEF_BITS-1:0]   req_coef_value,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic signed [SAMPLE_BITS-1:0] rsp_left_out,
   input  logic signed [SAMPLE_BITS-1:0] rsp_right_out,
   input  logic                          rsp_end_of_block_out,
   input  logic                          rsp_saturated,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [1:0]                    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   input  logic                          csr_pready,
   output int                            fail_count,
   output int                            pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] REG_WET_MIX = 2'd0;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] left;
      logic signed [SAMPLE_BITS-1:0] right;
      logic                          eob;
      logic                          sat;
   } mixed_pair_type;

   logic signed [COEF_BITS-1:0]  coef_tab [NCOEF];
   logic signed [DELAY_BITS-1:0] delay_tab [NDELAY];
   logic [15:0]                  wet_mix;
   mixed_pair_type               expected_pairs [$];

   // Round half up by the coefficient fraction and clip to a delay word.
   function automatic logic signed [DELAY_BITS-1:0] round_clip(
         input logic signed [127:0] acc, inout bit clip);
      logic signed [127:0] sh;
      sh = (acc + (128'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
      if (sh > 128'sd2147483647) begin
         clip = 1'b1;
         return 32'sh7FFFFFFF;
      end
      if (sh < -128'sd2147483648) begin
         clip = 1'b1;
         return 32'sh80000000;
      end
      return sh[DELAY_BITS-1:0];
   endfunction

   // Run one channel through the cascade, updating its delay words.
   function automatic logic signed [DELAY_BITS-1:0] filter_channel(
         input int ch, input logic signed [DELAY_BITS-1:0] x_in, inout bit clip);
      logic signed [127:0]          acc;
      logic signed [127:0]          xe;
      logic signed [DELAY_BITS-1:0] x;
      logic signed [DELAY_BITS-1:0] w;
      int                           c;
      int                           z;
      x = x_in;
      for (int s = 0; s < STAGES; s++) begin
         c = s * 5;
         z = (s * 2 + ch) * 2;
         xe = x;
         acc = xe <<< COEF_FRAC;
         acc = acc - coef_tab[c+3] * delay_tab[z];
         acc = acc - coef_tab[c+4] * delay_tab[z+1];
         w = round_clip(acc, clip);
         acc = coef_tab[c] * w;
         acc = acc + coef_tab[c+1] * delay_tab[z];
         acc = acc + coef_tab[c+2] * delay_tab[z+1];
         x = round_clip(acc, clip);
         delay_tab[z+1] = delay_tab[z];
         delay_tab[z] = w;
      end
      return x;
   endfunction

   // Dry/wet blend with rounding and clipping to a sample.
   function automatic logic signed [SAMPLE_BITS-1:0] blend(
         input longint dry, input longint wet, input longint mix, inout bit clip);
      longint o;
      o = dry + (((wet - dry) * mix + 16384) >>> 15);
      if (o > 64'sd8388607) begin
         o = 64'sd8388607;
         clip = 1'b1;
      end
      if (o < -64'sd8388608) begin
         o = -64'sd8388608;
         clip = 1'b1;
      end
      return o[SAMPLE_BITS-1:0];
   endfunction

   // Watch the ports, keep the model state and compare each result.
   always @(posedge clock) begin
      mixed_pair_type got;
      mixed_pair_type want;
      bit          clip;
      longint      mix;
      logic signed [DELAY_BITS-1:0] l_in;
      logic signed [DELAY_BITS-1:0] r_in;
      logic signed [DELAY_BITS-1:0] l_eq;
      logic signed [DELAY_BITS-1:0] r_eq;
      if (reset) begin
         for (int i = 0; i < NCOEF; i++)
            coef_tab[i] = (i % 5 == 0) ? (32'sd1 <<< COEF_FRAC) : 32'sd0;
         for (int i = 0; i < NDELAY; i++)
            delay_tab[i] = '0;
         wet_mix = MIX_ONE;
         expected_pairs.delete();
         fail_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == REG_WET_MIX)
            wet_mix = csr_pwdata[15:0];
         if (rsp_valid && rsp_ready) begin
            got.left = rsp_left_out;
            got.right = rsp_right_out;
            got.eob = rsp_end_of_block_out;
            got.sat = rsp_saturated;
            if (expected_pairs.size() == 0) begin
               $error("result with no request outstanding: left %0d right %0d",
                      got.left, got.right);
               fail_count++;
            end else begin
               want = expected_pairs.pop_front();
               if (got.left !== want.left) begin
                  $error("left_out: expected %0d, got %0d", want.left, got.left);
                  fail_count++;
               end
               if (got.right !== want.right) begin
                  $error("right_out: expected %0d, got %0d", want.right, got.right);
                  fail_count++;
               end
               if (got.eob !== want.eob) begin
                  $error("end_of_block_out: expected %0b, got %0b", want.eob, got.eob);
                  fail_count++;
               end
               if (got.sat !== want.sat) begin
                  $error("saturated: expected %0b, got %0b", want.sat, got.sat);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            case (req_func)
               FUNC_COEF: begin
                  if (req_coef_index < NCOEF)
                     coef_tab[req_coef_index] = req_coef_value;
               end
               FUNC_CLEAR: begin
                  for (int i = 0; i < NDELAY; i++)
                     delay_tab[i] = '0;
               end
               FUNC_SAMPLE: begin
                  clip = 1'b0;
                  mix = (wet_mix > MIX_ONE) ? longint'(MIX_ONE) : longint'(wet_mix);
                  l_in = req_left_sample;
                  r_in = req_right_sample;
                  l_eq = filter_channel(0, l_in, clip);
                  r_eq = filter_channel(1, r_in, clip);
                  want.left = blend(l_in, l_eq, mix, clip);
                  want.right = blend(r_in, r_eq, mix, clip);
                  want.eob = req_end_of_block;
                  want.sat = clip;
                  expected_pairs.push_back(want);
               end
               default: ;
            endcase
         end
      end
      pending_count = expected_pairs.size();
   end
endmodule

### tb/stereo_biquad_cascade_mix_core_tb.sv
// Top of the equaliser testbench: clock, reset, stimulus and the verdict.
module stereo_biquad_cascade_mix_core_tb;
   import sbq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int PHASE_ITEMS    = 80;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic [1:0]                    req_func;
   logic signed [SAMPLE_BITS-1:0] req_left_sample;
   logic signed [SAMPLE_BITS-1:0] req_right_sample;
   logic                          req_end_of_block;
   logic [CIDX_BITS-1:0]          req_coef_index;
   logic signed [COEF_BITS-1:0]   req_coef_value;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic signed [SAMPLE_BITS-1:0] rsp_left_out;
   logic signed [SAMPLE_BITS-1:0] rsp_right_out;
   logic                          rsp_end_of_block_out;
   logic                          rsp_saturated;
   logic                          csr_psel;
   logic                          csr_penable;
   logic                          csr_pwrite;
   logic [1:0]                    csr_paddr;
   logic [31:0]                   csr_pwdata;
   logic [31:0]                   csr_prdata;
   logic                          csr_pready;
   int                            fail_count;
   int                            pending_count;
   int                            send_idle_pct;
   int                            stall_pct;
   int                            quiet_cycles;

   stereo_biquad_cascade_mix_core DUT (.*);

   stereo_biquad_cascade_mix_core_checker checker_i (.*);

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Receiver stalls at the rate of the current phase.
   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= stall_pct);

   // Watchdog: ends the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_penable)
         quiet_cycles <= 0;
      else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("** stereo_biquad_cascade_mix_core: FAILED **");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   // Present one request and hold it until it is accepted.
   task automatic send_request(input logic [1:0] func, input int left, input int right,
                               input bit eob, input int idx, input int value);
      bit taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_func <= func;
      req_left_sample <= left[SAMPLE_BITS-1:0];
      req_right_sample <= right[SAMPLE_BITS-1:0];
      req_end_of_block <= eob;
      req_coef_index <= idx[CIDX_BITS-1:0];
      req_coef_value <= value;
      req_valid <= 1'b1;
      // Ready is sampled between edges, where it is settled.
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
   endtask

   // Let all results drain and the back end settle, then write the blend.
   task automatic write_wet_mix(input logic [15:0] mix);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (100) @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= '0;
      csr_pwdata <= {16'h0, mix};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Sample value biased towards the extremes now and then.
   function automatic int pick_sample();
      int r;
      r = $urandom_range(9);
      if (r == 0) return 8388607;
      if (r == 1) return -8388608;
      if (r == 2) return int'($urandom_range(2000)) - 1000;
      return int'($urandom_range(16777215)) - 8388608;
   endfunction

   // Mostly gentle coefficients, so the cascade stays out of clipping often.
   function automatic int pick_coef();
      if ($urandom_range(9) == 0) return int'($urandom());
      return int'($urandom_range(268435456)) - 134217728;
   endfunction

   // One random request: mostly sample pairs, with filter reloads and the odd oddity.
   task automatic send_random_request();
      int r;
      r = $urandom_range(99);
      if (r < 72)
         send_request(FUNC_SAMPLE, pick_sample(), pick_sample(), $urandom_range(1), 0, 0);
      else if (r < 90)
         send_request(FUNC_COEF, pick_sample(), pick_sample(), $urandom_range(1),
                      $urandom_range(NCOEF - 1), pick_coef());
      else if (r < 94)
         send_request(FUNC_CLEAR, pick_sample(), pick_sample(), $urandom_range(1), 0, 0);
      else if (r < 97)
         send_request(2'd3, pick_sample(), pick_sample(), $urandom_range(1),
                      $urandom_range(31), int'($urandom()));
      else
         send_request(FUNC_COEF, 0, 0, 0, $urandom_range(31, NCOEF), int'($urandom()));
   endtask

   initial begin
      logic [15:0] mixes [5];
      mixes = '{16'd0, 16'd32768, 16'd65535, 16'd16384, 16'd1};
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FUNC_SAMPLE;
      req_left_sample = '0;
      req_right_sample = '0;
      req_end_of_block = 1'b0;
      req_coef_index = '0;
      req_coef_value = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      send_idle_pct = 0;
      stall_pct = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes through the identity filter at full blend.
      send_request(FUNC_SAMPLE, 8388607, -8388608, 1'b1, 0, 0);
      send_request(FUNC_SAMPLE, -8388608, 8388607, 1'b0, 0, 0);
      send_request(FUNC_SAMPLE, 0, -1, 1'b1, 31, -1);
      // Unused function code and out-of-range coefficient slots change nothing.
      send_request(2'd3, 12345, -12345, 1'b1, 0, -1);
      send_request(FUNC_COEF, 0, 0, 1'b0, NCOEF, 32'sh7FFFFFFF);
      send_request(FUNC_COEF, 0, 0, 1'b0, 31, 32'sh80000000);
      send_request(FUNC_SAMPLE, 4000000, -4000000, 1'b0, 0, 0);
      // Large gain and feedback drive both the stages and the output into clipping.
      send_request(FUNC_COEF, 0, 0, 1'b0, 0, 32'sh7FFFFFFF);
      send_request(FUNC_COEF, 0, 0, 1'b0, 19, 32'sh80000000);
      send_request(FUNC_COEF, 0, 0, 1'b0, 8, 32'sh7FFFFFFF);
      send_request(FUNC_SAMPLE, 8388607, -8388608, 1'b1, 0, 0);
      send_request(FUNC_SAMPLE, 8388607, -8388608, 1'b0, 0, 0);
      send_request(FUNC_SAMPLE, 100, -100, 1'b1, 0, 0);
      send_request(FUNC_CLEAR, 0, 0, 1'b0, 0, 0);
      send_request(FUNC_SAMPLE, 100, -100, 1'b0, 0, 0);
      // Back to identity on the touched slots.
      send_request(FUNC_COEF, 0, 0, 1'b0, 0, 32'sd1 <<< COEF_FRAC);
      send_request(FUNC_COEF, 0, 0, 1'b0, 19, 0);
      send_request(FUNC_COEF, 0, 0, 1'b0, 8, 0);
      send_request(FUNC_SAMPLE, -8388608, 8388607, 1'b1, 0, 0);

      // Random phases over blend settings and idling patterns.
      for (int p = 0; p < 5; p++) begin
         write_wet_mix(p == 4 ? 16'($urandom_range(65535)) : mixes[p]);
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 76; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 76; end
            default: begin send_idle_pct = 38; stall_pct = 38; end
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++)
            send_random_request();
      end
      req_valid <= 1'b0;

      // Drain, then allow for the latency before the verdict.
      do @(posedge clock); while (pending_count != 0);
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("** stereo_biquad_cascade_mix_core: PASSED **");
      else
         $display("** stereo_biquad_cascade_mix_core: FAILED **");
      $finish;
   end
endmodule
